FILE: hw/rtl/bounded_list_table_defines.svh
// Assertion helpers shared by the table RTL.
`ifndef BOUNDED_LIST_TABLE_DEFINES_SVH
`define BOUNDED_LIST_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/blt_pkg.sv
package blt_pkg;

  localparam int DEF_CAPACITY  = 16;
  localparam int DEF_ELEM_BITS = 32;

  // Request / result field widths
  localparam int OP_W        = 3;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 4;
  localparam int IDX_OUT_W   = 4;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND       = 3'd0,
    OP_REMOVE       = 3'd1,
    OP_REMOVE_FIRST = 3'd2,
    OP_FIND         = 3'd3,
    OP_READ         = 3'd4
  } op_t;

  // What a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_KEY,
    CELL_NEXT,
    CELL_LAST
  } cell_mode_t;

  typedef struct packed {
    logic       cmp_en;
    cell_mode_t mode;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/blt_cell.sv
module blt_cell #(
  parameter int ELEM_BITS = blt_pkg::DEF_ELEM_BITS,
  parameter int CNT_W     = 5,
  parameter int IDX_W     = 4,
  parameter int IDX       = 0
) (
  input  logic                  clk,
  input  blt_pkg::cell_ctl_t    ctl,
  input  logic [ELEM_BITS-1:0]  key,
  input  logic [CNT_W-1:0]      fill,
  input  logic [IDX_W-1:0]      sel_idx,
  input  logic [ELEM_BITS-1:0]  next_entry,
  input  logic [ELEM_BITS-1:0]  last_entry,
  output logic [ELEM_BITS-1:0]  entry_q,
  output logic                  hit_r,
  output logic [ELEM_BITS-1:0]  rd_r
);

  logic [ELEM_BITS-1:0] entry_r;

  assign entry_q = entry_r;

  always_ff @(posedge clk) begin
    case (ctl.mode)
      blt_pkg::CELL_KEY:  entry_r <= key;
      blt_pkg::CELL_NEXT: entry_r <= next_entry;
      blt_pkg::CELL_LAST: entry_r <= last_entry;
      default:            entry_r <= entry_r;
    endcase
    if (ctl.cmp_en) begin
      // only live entries may match
      hit_r <= (entry_r == key) && (CNT_W'(IDX) < fill);
      rd_r  <= (sel_idx == IDX_W'(IDX)) ? entry_r : '0;
    end
  end

endmodule

FILE: hw/rtl/bounded_list_table.sv
// Bounded list table: up to CAPACITY entries of ELEM_BITS bits and a count.
// Requests come in on in_t* (op, value, position); each one yields exactly
// one result on out_t* (ok, found_index, data, count after the request).
// Ops: append, remove by value (later entries shift down, order kept),
// remove first (last entry moves to slot 0), find, read at index.
// Timing: a request accepted at edge T is compared in every cell during the
// next cycle (match bits and read selection registered); the table and the
// result register are then updated in the S_EXEC state, where out_tvalid
// rises. in_tready is high only while no request is in flight, so a new
// request is not taken until the last one has passed the registered
// compare stage in the cell row and the update stage.
// The result sits in an output register: a request may be accepted while
// the previous result waits; if the receiver stalls, the update stage
// holds until the output register is free, so nothing is lost.
// Reset (rst_n low, synchronous) clears the count and the handshakes.
// Entry contents are unspecified after reset; no clearing pass is run.
module bounded_list_table #(
  parameter int CAPACITY  = blt_pkg::DEF_CAPACITY,
  parameter int ELEM_BITS = blt_pkg::DEF_ELEM_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] op, [34:3] value, [38:35] position, [39] zero
  input  logic [blt_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] ok, [4:1] found_index, [36:5] data, [41:37] count, [47:42] zero
  output logic [blt_pkg::OUT_TDATA_W-1:0]  out_tdata
);

`include "bounded_list_table_defines.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > blt_pkg::POS_W) ? CNT_W : blt_pkg::POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  state_t                         state_r;
  logic [blt_pkg::OP_W-1:0]       op_r;
  logic [ELEM_BITS-1:0]           key_r;
  logic [blt_pkg::POS_W-1:0]      pos_r;
  logic [CNT_W-1:0]               fill_r;
  logic                           out_tvalid_r;
  logic                           out_ok_r;
  logic [blt_pkg::IDX_OUT_W-1:0]  out_idx_r;
  logic [blt_pkg::DATA_W-1:0]     out_data_r;
  logic [blt_pkg::COUNT_W-1:0]    out_count_r;

  logic [ELEM_BITS-1:0]  entry_q [CAPACITY];
  logic [ELEM_BITS-1:0]  rd_q    [CAPACITY];
  logic [CAPACITY-1:0]   hit;
  blt_pkg::cell_ctl_t    ctl     [CAPACITY];

  logic [IDX_W-1:0]      sel_idx;
  logic [CAPACITY-1:0]   neg_hit;
  logic [CAPACITY-1:0]   low_hit;
  logic [CAPACITY-1:0]   shift_mask;
  logic                  any_hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [ELEM_BITS-1:0]  rd_or;
  logic                  fire;
  logic                  ok_nxt;
  logic [IDX_W-1:0]      idx_nxt;
  logic [ELEM_BITS-1:0]  data_nxt;
  logic [CNT_W-1:0]      fill_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(blt_pkg::OUT_TDATA_W - 42){1'b0}},
                       out_count_r, out_data_r, out_idx_r, out_ok_r};

  // read port: requested index for reads, tail entry for remove-first
  assign sel_idx = (op_r == blt_pkg::OP_READ) ? IDX_W'(pos_r)
                                              : IDX_W'(fill_r - CNT_W'(1));

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ELEM_BITS-1:0] next_entry;
      if (g == CAPACITY - 1) begin : g_tail
        assign next_entry = '0;
      end else begin : g_body
        assign next_entry = entry_q[g+1];
      end
      blt_cell #(
        .ELEM_BITS (ELEM_BITS),
        .CNT_W     (CNT_W),
        .IDX_W     (IDX_W),
        .IDX       (g)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl[g]),
        .key        (key_r),
        .fill       (fill_r),
        .sel_idx    (sel_idx),
        .next_entry (next_entry),
        .last_entry (rd_or),
        .entry_q    (entry_q[g]),
        .hit_r      (hit[g]),
        .rd_r       (rd_q[g])
      );
    end
  endgenerate

  // first match: lowest set bit, and everything from it upward shifts
  always_comb begin
    neg_hit    = ~hit + CAPACITY'(1);
    low_hit    = hit & neg_hit;
    shift_mask = ~(low_hit - CAPACITY'(1));
    any_hit    = |hit;
    hit_idx    = '0;
    rd_or      = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (low_hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      rd_or = rd_or | rd_q[i];
    end
  end

  assign fire = (state_r == S_EXEC) && (!out_tvalid_r || out_tready);

  always_comb begin
    ok_nxt   = 1'b0;
    idx_nxt  = '0;
    data_nxt = '0;
    fill_nxt = fill_r;
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].cmp_en = (state_r == S_CMP);
      ctl[i].mode   = blt_pkg::CELL_HOLD;
    end
    if (fire) begin
      case (op_r)
        blt_pkg::OP_APPEND: begin
          if (fill_r < CNT_W'(CAPACITY)) begin
            ok_nxt   = 1'b1;
            fill_nxt = fill_r + CNT_W'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (CNT_W'(i) == fill_r) begin
                ctl[i].mode = blt_pkg::CELL_KEY;
              end
            end
          end
        end
        blt_pkg::OP_REMOVE: begin
          if (any_hit) begin
            ok_nxt   = 1'b1;
            idx_nxt  = hit_idx;
            fill_nxt = fill_r - CNT_W'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (shift_mask[i]) begin
                ctl[i].mode = blt_pkg::CELL_NEXT;
              end
            end
          end
        end
        blt_pkg::OP_REMOVE_FIRST: begin
          if (fill_r != '0) begin
            ok_nxt      = 1'b1;
            data_nxt    = entry_q[0];
            fill_nxt    = fill_r - CNT_W'(1);
            ctl[0].mode = blt_pkg::CELL_LAST;
          end
        end
        blt_pkg::OP_FIND: begin
          if (any_hit) begin
            ok_nxt  = 1'b1;
            idx_nxt = hit_idx;
          end
        end
        blt_pkg::OP_READ: begin
          if (CMP_W'(pos_r) < CMP_W'(fill_r)) begin
            ok_nxt   = 1'b1;
            data_nxt = rd_or;
          end
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tdata[2:0];
            key_r   <= ELEM_BITS'(in_tdata[34:3]);
            pos_r   <= in_tdata[38:35];
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (fire) begin
            fill_r      <= fill_nxt;
            out_ok_r    <= ok_nxt;
            out_idx_r   <= blt_pkg::IDX_OUT_W'(idx_nxt);
            out_data_r  <= blt_pkg::DATA_W'(data_nxt);
            out_count_r <= blt_pkg::COUNT_W'(fill_nxt);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `BLT_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CNT_W'(CAPACITY), "count exceeds capacity")
  `BLT_ASSERT_NOW(a_fill_exec, $past(rst_n) && (fill_r != $past(fill_r)), $past(state_r) == S_EXEC, "count moved outside update stage")
  `BLT_ASSERT_NOW(a_result_exec, $past(rst_n) && $rose(out_tvalid_r), $past(state_r) == S_EXEC, "result raised outside update stage")
  `BLT_ASSERT_NEXT(a_exec_hold, (state_r == S_EXEC) && out_tvalid_r && !out_tready, state_r == S_EXEC, "update stage left while result stalled")

endmodule

FILE: bench/bounded_list_table_test.sv
`timescale 1ns / 100ps

module bounded_list_table_test;
  import blt_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 850;
  localparam int GRACE_CYCLES = 10;

  typedef logic [CAP-1:0][DEF_ELEM_BITS-1:0] slot_array_t;

  // Request fields, lowest bit first: op, value, position
  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    logic [OP_W-1:0]    op;
  } list_req_t;

  // Result fields, lowest bit first: ok, found_index, data, count
  typedef struct packed {
    logic [COUNT_W-1:0]   count;
    logic [DATA_W-1:0]    data;
    logic [IDX_OUT_W-1:0] found_index;
    logic                 ok;
  } list_resp_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  bounded_list_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  list_req_t  request_queue[$];
  list_resp_t pending_results[$];

  // Shadow copy used while building stimulus, and the copy that tracks the block
  slot_array_t        plan_slots;
  logic [COUNT_W-1:0] plan_fill;
  slot_array_t        live_slots;
  logic [COUNT_W-1:0] live_fill;

  logic in_taken;
  int   in_gap;
  int   out_gap;
  int   launched;
  int   results_seen;
  int   errors;

  always #2 clk = ~clk;

  // One list operation: updates the table in place and returns the result.
  function automatic list_resp_t list_apply(inout slot_array_t slots,
                                            inout logic [COUNT_W-1:0] fill,
                                            input list_req_t r);
    list_resp_t res;
    int k;
    int hit;
    res = '0;
    hit = -1;
    for (k = 0; k < CAP; k++) begin
      if (hit < 0 && k < int'(fill) && slots[k] == r.value) hit = k;
    end
    case (r.op)
      OP_APPEND: begin
        if (int'(fill) < CAP) begin
          slots[fill] = r.value;
          fill = fill + 1'b1;
          res.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          res.ok = 1'b1;
          res.found_index = IDX_OUT_W'(hit);
          for (k = hit; k < CAP - 1; k++) begin
            if (k + 1 < int'(fill)) slots[k] = slots[k+1];
          end
          fill = fill - 1'b1;
        end
      end
      OP_REMOVE_FIRST: begin
        if (fill != '0) begin
          res.ok = 1'b1;
          res.data = slots[0];
          slots[0] = slots[fill - 1'b1];
          fill = fill - 1'b1;
        end
      end
      OP_FIND: begin
        if (hit >= 0) begin
          res.ok = 1'b1;
          res.found_index = IDX_OUT_W'(hit);
        end
      end
      OP_READ: begin
        if (COUNT_W'(r.position) < fill) begin
          res.ok = 1'b1;
          res.data = slots[r.position];
        end
      end
      default: ;
    endcase
    res.count = fill;
    return res;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Corner values show up often so that duplicates and extremes are common.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(VALUE_W-1){1'b0}}};
      3: return VALUE_W'(1);
      4: return {VALUE_W/8{8'h5a}};
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] position);
    list_req_t r;
    list_resp_t unused;
    r.op = op;
    r.value = value;
    r.position = position;
    request_queue.push_back(r);
    unused = list_apply(plan_slots, plan_fill, r);
  endtask

  // Driver: requests change on the falling edge, valid held until taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_taken) begin
        in_tvalid <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        in_tdata <= IN_TDATA_W'(request_queue.pop_front());
        in_tvalid <= 1'b1;
        in_gap <= pick_gap((launched / 64) % 4 == 1);
        launched <= launched + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= pick_gap((results_seen / 64) % 4 == 2);
      end
    end
  end

  // Monitor: predict on request acceptance, check on result acceptance
  always @(posedge clk) begin
    list_resp_t want;
    list_resp_t got;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(list_apply(live_slots, live_fill,
                                             list_req_t'(in_tdata[$bits(list_req_t)-1:0])));
      end
      if (out_tvalid && out_tready) begin
        got = list_resp_t'(out_tdata[$bits(list_resp_t)-1:0]);
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("unexpected result: ok=%0d idx=%0d data=%h count=%0d",
                     got.ok, got.found_index, got.data, got.count);
        end else begin
          want = pending_results.pop_front();
          if (got.ok !== want.ok || got.found_index !== want.found_index ||
              got.data !== want.data || got.count !== want.count) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: expected ok=%0d idx=%0d data=%h count=%0d, got ok=%0d idx=%0d data=%h count=%0d",
                       want.ok, want.found_index, want.data, want.count,
                       got.ok, got.found_index, got.data, got.count);
          end
        end
      end
    end
  end

  initial begin
    int k;
    int counted;
    int w;
    logic [OP_W-1:0] op;
    logic [VALUE_W-1:0] v;
    logic [POS_W-1:0] p;

    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    in_taken = 1'b0;
    in_gap = 0;
    out_gap = 0;
    launched = 0;
    results_seen = 0;
    errors = 0;
    plan_slots = '0;
    plan_fill = '0;
    live_slots = '0;
    live_fill = '0;

    // Empty table: every lookup misses, then the unused op codes
    queue_request(OP_REMOVE_FIRST, '0, '0);
    queue_request(OP_FIND, '0, '0);
    queue_request(OP_REMOVE, '1, '0);
    queue_request(OP_READ, '0, '0);
    for (k = int'(OP_READ) + 1; k < (1 << OP_W); k++) queue_request(OP_W'(k), '1, '1);
    // Fill up, with a duplicate of 1 further down, then one append too many
    for (k = 0; k <= CAP; k++) begin
      case (k)
        0: v = '0;
        1: v = '1;
        2: v = {1'b1, {(VALUE_W-1){1'b0}}};
        3, 9: v = VALUE_W'(1);
        default: v = $urandom;
      endcase
      queue_request(OP_APPEND, v, '0);
    end
    queue_request(OP_READ, '0, '1);
    queue_request(OP_FIND, VALUE_W'(1), '0);
    queue_request(OP_REMOVE, VALUE_W'(1), '0);
    queue_request(OP_READ, '0, '1);
    queue_request(OP_REMOVE_FIRST, '0, '0);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      w = $urandom_range(0, 99);
      if (w < 3) begin
        op = OP_W'($urandom_range(int'(OP_READ) + 1, (1 << OP_W) - 1));
      end else if (w < 33 + (8 - int'(plan_fill)) * 3) begin
        op = OP_APPEND;
      end else begin
        case ($urandom_range(0, 3))
          0: op = OP_REMOVE;
          1: op = OP_REMOVE_FIRST;
          2: op = OP_FIND;
          default: op = OP_READ;
        endcase
      end
      if (plan_fill != '0 && (op == OP_REMOVE || op == OP_FIND) && $urandom_range(0, 99) < 65)
        v = plan_slots[$urandom_range(0, int'(plan_fill) - 1)];
      else
        v = pick_value();
      if (plan_fill != '0 && $urandom_range(0, 99) < 75)
        p = POS_W'($urandom_range(0, int'(plan_fill) - 1));
      else
        p = POS_W'($urandom_range(0, CAP - 1));
      queue_request(op, v, p);
      if (op <= OP_READ) counted++;
    end

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (request_queue.size() > 0 || in_tvalid) @(negedge clk);
    while (pending_results.size() > 0) @(negedge clk);
    repeat (GRACE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
